@@ hw/rtl/content_defined_chunker_top_macros.svh @@
// assertion macros shared by the chunker rtl
`ifndef CONTENT_DEFINED_CHUNKER_TOP_MACROS_SVH
`define CONTENT_DEFINED_CHUNKER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define CDCHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define CDCHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDCHK_ASSERT(label, prop, msg)
`define CDCHK_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ hw/rtl/cdchk_pkg.sv @@
// types and constants of the content defined chunker
package cdchk_pkg;

  localparam int LenW = 24;
  localparam int CfgIdxW = 3;
  localparam logic [LenW-1:0] LEN_MAX = 24'hFFFFFF;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PRIME        = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_POWER = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MATCH_MASK   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MIN_SIZE     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_SIZE     = 3'd4;

  // cut reason codes
  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_CONTENT = 2'd1;
  localparam logic [1:0] REASON_MAX     = 2'd2;
  localparam logic [1:0] REASON_LAST    = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      byte_out;
    logic            chunk_end;
    logic [1:0]      cut_reason;
    logic [LenW-1:0] chunk_length;
  } out_item_t;

  typedef struct packed {
    logic [31:0]     prime;
    logic [31:0]     window_power;
    logic [31:0]     match_mask;
    logic [LenW-1:0] min_size;
    logic [LenW-1:0] max_size;
  } cfg_t;

  // item after the ring access: new byte plus the byte it displaced
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
    logic [7:0] old_byte;
  } stage1_t;

endpackage

@@ hw/rtl/cdchk_cfg.sv @@
// configuration register file of the chunker
module cdchk_cfg import cdchk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  output cfg_t               regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.prime        <= 32'd31;
      regs.window_power <= 32'd0;
      regs.match_mask   <= 32'd4095;
      regs.min_size     <= 24'd2048;
      regs.max_size     <= 24'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRIME:        regs.prime        <= cfg_data;
        REG_WINDOW_POWER: regs.window_power <= cfg_data;
        REG_MATCH_MASK:   regs.match_mask   <= cfg_data;
        REG_MIN_SIZE:     regs.min_size     <= cfg_data[LenW-1:0];
        REG_MAX_SIZE:     regs.max_size     <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/cdchk_ring.sv @@
// window ring memory and the first pipeline stage
`include "content_defined_chunker_top_macros.svh"

module cdchk_ring import cdchk_pkg::*; #(
  parameter int WINDOW_BYTES = 48
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     data_valid,
  output logic     data_stall,
  input  in_item_t data_item,
  input  logic     take,
  output logic     s1_valid,
  output stage1_t  s1_item
);

  localparam int PtrW = $clog2(WINDOW_BYTES);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(WINDOW_BYTES - 1);

  logic [7:0]      ring [WINDOW_BYTES];
  logic [PtrW-1:0] ptr;
  logic            s1_free;
  logic            accept;

  assign s1_free    = !s1_valid || take;
  assign data_stall = !s1_free;
  assign accept     = data_valid && s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        ptr <= (ptr == PtrLast) ? '0 : ptr + 1'b1;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // read-first access: old byte out, new byte in, same slot
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.old_byte     <= ring[ptr];
      ring[ptr]            <= data_item.data_byte;
      s1_item.data_byte    <= data_item.data_byte;
      s1_item.end_of_input <= data_item.end_of_input;
    end
  end

  `CDCHK_ASSERT(a_s1_hold, s1_valid && !take |=> s1_valid && $stable(s1_item), "stage 1 item lost while stalled")
  `CDCHK_ASSERT(a_ptr_step, accept |=> ptr != $past(ptr), "ring pointer did not advance")
  `CDCHK_ASSERT_ALWAYS(a_stall_full, data_stall |-> s1_valid, "stall raised with empty stage")

endmodule

@@ hw/rtl/cdchk_hash.sv @@
// eviction product, rolling hash update, cut decision and result register
`include "content_defined_chunker_top_macros.svh"

module cdchk_hash import cdchk_pkg::*; #(
  parameter int WINDOW_BYTES = 48
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      regs,
  input  logic      s1_valid,
  input  stage1_t   s1_item,
  output logic      take,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result_item
);

  localparam logic [LenW-1:0] WinLen = LenW'(WINDOW_BYTES);

  logic            s2_valid;
  logic [7:0]      s2_byte;
  logic            s2_last;
  logic [31:0]     s2_evict;
  logic [31:0]     evict_next;
  logic            out_free;
  logic            s2_move;
  logic            s1_move;

  logic [31:0]     rolling_hash;
  logic [LenW-1:0] bytes_in_chunk;
  logic [LenW-1:0] count;
  logic [31:0]     hash_mix;
  logic [31:0]     hash_new;
  logic [1:0]      reason;
  logic            cut;

  assign out_free = !result_valid || !result_stall;
  assign s2_move  = s2_valid && out_free;
  assign take     = !s2_valid || s2_move;
  assign s1_move  = s1_valid && take;

  // oldest byte times prime^window, ready one stage ahead
  assign evict_next = regs.window_power * {24'd0, s1_item.old_byte};

  always_comb begin
    count    = (bytes_in_chunk == LEN_MAX) ? bytes_in_chunk : bytes_in_chunk + 1'b1;
    hash_mix = rolling_hash * regs.prime + {24'd0, s2_byte};
    hash_new = (count > WinLen) ? hash_mix - s2_evict : hash_mix;
    if (count >= WinLen && count >= regs.min_size && (hash_new & regs.match_mask) == 32'd0) begin
      reason = REASON_CONTENT;
    end else if (count >= regs.max_size) begin
      reason = REASON_MAX;
    end else if (s2_last) begin
      reason = REASON_LAST;
    end else begin
      reason = REASON_NONE;
    end
    cut = (reason != REASON_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid       <= 1'b0;
      result_valid   <= 1'b0;
      rolling_hash   <= '0;
      bytes_in_chunk <= '0;
    end else begin
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        result_valid   <= 1'b1;
        rolling_hash   <= cut ? 32'd0 : hash_new;
        bytes_in_chunk <= cut ? '0 : count;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_byte  <= s1_item.data_byte;
      s2_last  <= s1_item.end_of_input;
      s2_evict <= evict_next;
    end
    if (s2_move) begin
      result_item.byte_out     <= s2_byte;
      result_item.chunk_end    <= cut;
      result_item.cut_reason   <= reason;
      result_item.chunk_length <= count;
    end
  end

  `CDCHK_ASSERT(a_restart, s2_move && cut |=> rolling_hash == '0 && bytes_in_chunk == '0, "no restart")
  `CDCHK_ASSERT(a_count, s2_move && !cut |=> bytes_in_chunk == $past(count), "length stuck")
  `CDCHK_ASSERT(a_content_len, result_valid && result_item.cut_reason == REASON_CONTENT |-> result_item.chunk_length >= WinLen, "early cut")

endmodule

@@ hw/rtl/content_defined_chunker_top.sv @@
// top level of the content defined chunker
//
// usage
//   data channel: one stream byte per item (data_valid / data_stall), with a
//   flag on the last byte of the stream. result channel: one item per byte
//   (result_valid / result_stall) carrying the byte, a chunk end flag, the
//   cut reason and the chunk length so far.
//   cfg channel: register writes (cfg_valid / cfg_ready, always ready),
//   index 0 prime, 1 window power, 2 cut mask, 3 min size, 4 max size.
//   write only while no item is in flight.
// timing
//   one item per cycle while result_stall is low; a result is registered
//   after the ring read, eviction product and hash update stages; the hash
//   update multiply, add and mask compare set the cycle time
// reset
//   rst clears the pipeline, hash, length and ring pointer and loads the
//   register defaults. the ring memory is not cleared; a slot's old byte only
//   counts after a full window of writes inside the current chunk.
// stall
//   a stalled result holds; items fill the stage 1 and stage 2 registers
//   that are still empty before data_stall rises.
module content_defined_chunker_top import cdchk_pkg::*; #(
  parameter int WINDOW_BYTES = 48
) (
  input  logic               clk,
  input  logic               rst,
  // byte items in
  input  logic               data_valid,
  output logic               data_stall,
  input  in_item_t           data_item,
  // result items out
  output logic               result_valid,
  input  logic               result_stall,
  output out_item_t          result_item,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t    regs;      // current configuration
  logic    s1_valid;  // item holds its displaced ring byte
  stage1_t s1_item;
  logic    take;      // hash side can take the stage 1 item

  cdchk_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // window ring: read old byte and write new byte at one slot per item
  cdchk_ring #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_item  (data_item),
    .take       (take),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item)
  );

  // eviction product, hash update, cut decision, result register
  cdchk_hash #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_hash (
    .clk          (clk),
    .rst          (rst),
    .regs         (regs),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

@@ verif/content_defined_chunker_top_tb.sv @@
// self-checking testbench for the content defined chunker top level
module content_defined_chunker_top_tb;
  import cdchk_pkg::*;

  localparam int WINDOW      = 48;    // rolling hash window, must match the dut
  localparam int IDLE_LIMIT  = 4000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 200;   // long receiver hold-off in the pressure test
  localparam int TAIL_CYCLES = 6;     // pipeline is three deep, leave some margin
  localparam int MAX_PRINTS  = 40;    // mismatch lines printed before going quiet

  // receiver stall behavior
  typedef enum int {RX_READY, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic               clk;
  logic               rst;
  logic               data_valid;
  logic               data_stall;
  in_item_t           data_item;
  logic               result_valid;
  logic               result_stall;
  out_item_t          result_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_data;

  content_defined_chunker_top #(
    .WINDOW_BYTES(WINDOW)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_item    (data_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // chunker prediction: own copy of the registers and the hash state
  // ---------------------------------------------------------------------------
  logic [31:0]     cfg_prime;
  logic [31:0]     cfg_wpow;
  logic [31:0]     cfg_mask;
  logic [LenW-1:0] cfg_min;
  logic [LenW-1:0] cfg_max;

  logic [31:0]     hash_state;
  logic [LenW-1:0] chunk_bytes;
  logic [7:0]      ring_mem [WINDOW];
  int              ring_slot;

  out_item_t byte_results [$];  // predicted result per accepted byte, oldest first

  int fail_count;
  int bytes_checked;
  int chunks_seen;
  int cut_count [4];

  // sender and receiver traffic knobs
  bit       gaps_on;
  int       burst_left;
  rx_mode_e rx_mode;
  int       rx_period;
  int       rx_duty;
  int       rx_tick;
  int       hold_left;
  int       idle_cycles;

  // prime^WINDOW mod 2^32, the factor that takes the oldest byte out of the hash
  function automatic logic [31:0] prime_to_window(input logic [31:0] p);
    logic [31:0] acc;
    acc = 32'd1;
    for (int k = 0; k < WINDOW; k++) acc = acc * p;
    return acc;
  endfunction

  // advance the chunker state by one byte and return the result it causes
  function automatic out_item_t chunker_step(input in_item_t it);
    out_item_t       r;
    logic [LenW-1:0] count;
    logic [1:0]      why;
    int              slot;
    count = chunk_bytes;
    if (count != LEN_MAX) count = count + 1'b1;
    slot = ring_slot;
    hash_state = hash_state * cfg_prime + 32'(it.data_byte);
    // a full window inside this chunk: drop the byte that entered WINDOW steps ago
    if (count > WINDOW) hash_state = hash_state - 32'(ring_mem[slot]) * cfg_wpow;
    ring_mem[slot] = it.data_byte;
    ring_slot = (slot == WINDOW - 1) ? 0 : slot + 1;
    // first reason wins: content match, then maximum size, then end of input
    if (count >= WINDOW && count >= cfg_min && (hash_state & cfg_mask) == 32'd0)
      why = REASON_CONTENT;
    else if (count >= cfg_max)
      why = REASON_MAX;
    else if (it.end_of_input)
      why = REASON_LAST;
    else
      why = REASON_NONE;
    r.byte_out     = it.data_byte;
    r.chunk_end    = (why != REASON_NONE);
    r.cut_reason   = why;
    r.chunk_length = count;
    if (why != REASON_NONE) begin
      hash_state  = 32'd0;
      chunk_bytes = '0;
    end else begin
      chunk_bytes = count;
    end
    return r;
  endfunction

  task automatic report_error(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: register writes, byte predictions and result checks on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    string     bad;
    if (rst) begin
      cfg_prime   = 32'd31;
      cfg_wpow    = 32'd0;
      cfg_mask    = 32'd4095;
      cfg_min     = 24'd2048;
      cfg_max     = 24'd65536;
      hash_state  = 32'd0;
      chunk_bytes = '0;
      ring_slot   = 0;
      for (int k = 0; k < WINDOW; k++) ring_mem[k] = 8'd0;
      byte_results.delete();
    end else begin
      // register writes only happen with nothing in flight
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRIME:        cfg_prime = cfg_data;
          REG_WINDOW_POWER: cfg_wpow  = cfg_data;
          REG_MATCH_MASK:   cfg_mask  = cfg_data;
          REG_MIN_SIZE:     cfg_min   = cfg_data[LenW-1:0];
          REG_MAX_SIZE:     cfg_max   = cfg_data[LenW-1:0];
          default: ;
        endcase
      end
      if (data_valid && !data_stall)
        byte_results.insert(byte_results.size(), chunker_step(data_item));
      if (result_valid && !result_stall) begin
        if (byte_results.size() == 0) begin
          report_error($sformatf("result byte %02h with no byte outstanding",
                                 result_item.byte_out));
        end else begin
          want = byte_results.pop_front();
          bad = "";
          if (result_item.byte_out !== want.byte_out)         bad = {bad, " byte_out"};
          if (result_item.chunk_end !== want.chunk_end)       bad = {bad, " chunk_end"};
          if (result_item.cut_reason !== want.cut_reason)     bad = {bad, " cut_reason"};
          if (result_item.chunk_length !== want.chunk_length) bad = {bad, " chunk_length"};
          if (bad != "")
            report_error($sformatf(
              "result %0d wrong%s: got %02h/%0b/%0d/%0d, want %02h/%0b/%0d/%0d",
              bytes_checked, bad,
              result_item.byte_out, result_item.chunk_end,
              result_item.cut_reason, result_item.chunk_length,
              want.byte_out, want.chunk_end, want.cut_reason, want.chunk_length));
          if (want.chunk_end) chunks_seen++;
          cut_count[want.cut_reason]++;
        end
        bytes_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: gives up after a long stretch without any handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, byte_results.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, plus a counted long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    result_stall = 1'b0;
    rx_tick = 0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_left > 0) begin
        result_stall = 1'b1;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_READY:   result_stall = 1'b0;
          RX_RANDOM:  result_stall = ($urandom_range(0, 99) < 30);
          RX_PATTERN: result_stall = ((rx_tick % rx_period) < rx_duty);
          default:    result_stall = 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving tasks: each one starts and ends just after a falling edge
  // ---------------------------------------------------------------------------
  task automatic set_traffic(input bit gaps, input rx_mode_e mode);
    gaps_on    = gaps;
    rx_mode    = mode;
    rx_period  = $urandom_range(2, 8);
    rx_duty    = $urandom_range(1, rx_period - 1);
    burst_left = $urandom_range(1, 24);
  endtask

  // offer one byte and hold it until accepted, then maybe open a gap
  task automatic send_byte(input logic [7:0] b, input logic last);
    data_item.data_byte    = b;
    data_item.end_of_input = last;
    data_valid = 1'b1;
    do @(posedge clk); while (data_stall);
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        // idle gap with junk on the payload, which the dut must ignore
        data_valid = 1'b0;
        data_item.data_byte    = 8'($urandom);
        data_item.end_of_input = 1'($urandom);
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop sending until every predicted result is back, then let the pipe settle
  task automatic wait_drained();
    data_valid = 1'b0;
    while (byte_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic [31:0] p, input logic [31:0] wpow,
                            input logic [31:0] mask, input logic [31:0] min_sz,
                            input logic [31:0] max_sz);
    wait_drained();
    write_reg(REG_PRIME, p);
    write_reg(REG_WINDOW_POWER, wpow);
    write_reg(REG_MATCH_MASK, mask);
    write_reg(REG_MIN_SIZE, min_sz);
    write_reg(REG_MAX_SIZE, max_sz);
  endtask

  // n random bytes; narrow picks from four values so the hash repeats itself
  task automatic run_stream(input int n, input int last_pct, input bit narrow);
    logic [7:0] b;
    logic       last;
    for (int k = 0; k < n; k++) begin
      b    = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom);
      last = ($urandom_range(0, 99) < last_pct);
      send_byte(b, last);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // register defaults: no content cut this early, only the end of input flag
  task automatic test_reset_values();
    set_traffic(1'b0, RX_READY);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    run_stream(6, 0, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b1);
  endtask

  // maximum size cuts, max size against end of input, unused register indexes
  task automatic test_forced_cuts();
    // zero max size: every byte is its own chunk, even a flagged last byte
    set_config(32'd31, prime_to_window(32'd31), 32'hFFFF_FFFF, 32'd16, 32'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    wait_drained();
    write_reg(REG_MAX_SIZE, 32'd4);
    // max size and end of input on the same byte: max size wins
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);
    // writes to unused indexes must change nothing
    wait_drained();
    for (int k = int'(REG_MAX_SIZE) + 1; k < (1 << CfgIdxW); k++)
      write_reg(CfgIdxW'(k), $urandom);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);
  endtask

  // window sized chunks with an all-zero mask so every eligible byte matches
  task automatic test_window_cut();
    logic [31:0] wp;
    wp = prime_to_window(32'd31);
    set_traffic(1'b1, RX_RANDOM);
    // zero min size; content, max size and end of input all hold on byte 48
    set_config(32'd31, wp, 32'd0, 32'd0, WINDOW);
    run_stream(WINDOW - 1, 0, 1'b0);
    send_byte(8'($urandom), 1'b1);
    // min size above the window: cut lands on the min size
    set_config(32'd31, wp, 32'd0, 32'd50, 32'd100);
    run_stream(60, 0, 1'b0);
    send_byte(8'($urandom), 1'b1);
  endtask

  // random registers chosen so content cuts are reachable, varied traffic
  task automatic test_random_settings();
    logic [31:0] p;
    logic [31:0] wp;
    logic [31:0] mask;
    int          min_sz;
    int          max_sz;
    for (int s = 0; s < 5; s++) begin
      p = $urandom;
      if ($urandom_range(0, 3) != 0) p[0] = 1'b1;
      // mostly the true eviction factor, sometimes anything at all
      wp = ($urandom_range(0, 4) == 0) ? $urandom : prime_to_window(p);
      mask = 32'd0;
      repeat ($urandom_range(1, 4)) mask[$urandom_range(0, 31)] = 1'b1;
      min_sz = $urandom_range(1, 100);
      max_sz = (s % 2 == 1) ? $urandom_range(min_sz, 150) : $urandom_range(min_sz, 2000);
      set_config(p, wp, mask, min_sz, max_sz);
      case (s % 3)
        0: set_traffic(1'b1, RX_RANDOM);
        1: set_traffic(1'b1, RX_PATTERN);
        default: set_traffic(1'b0, RX_READY);
      endcase
      run_stream(150, 3, s == 2);
    end
  endtask

  // receiver holds off long enough to back the dut up into its input
  task automatic test_backpressure();
    set_config(32'd257, prime_to_window(32'd257), 32'h0000_0003, 32'd48, 32'd300);
    set_traffic(1'b0, RX_READY);
    hold_left = HOLD_CYCLES;
    run_stream(40, 2, 1'b0);
    // sender pauses until every result is in
    wait_drained();
    set_traffic(1'b1, RX_PATTERN);
    run_stream(40, 2, 1'b0);
  endtask

  // all-ones and all-zero registers, min and max written with upper bits set
  task automatic test_extreme_settings();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_traffic(1'b1, RX_RANDOM);
    run_stream(120, 2, 1'b0);
    // upper bits dropped: min size zero, max size 64
    set_config(32'd0, 32'd0, 32'd0, 32'hFF00_0000, 32'h0100_0040);
    set_traffic(1'b1, RX_PATTERN);
    run_stream(100, 1, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    data_valid  = 1'b0;
    data_item   = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    gaps_on     = 1'b0;
    burst_left  = 0;
    rx_mode     = RX_READY;
    rx_period   = 2;
    rx_duty     = 1;
    hold_left   = 0;
    idle_cycles = 0;
    fail_count  = 0;
    bytes_checked = 0;
    chunks_seen = 0;
    for (int k = 0; k < 4; k++) cut_count[k] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_forced_cuts();
    test_window_cut();
    test_random_settings();
    test_backpressure();
    test_extreme_settings();
    wait_drained();

    if (byte_results.size() != 0)
      report_error($sformatf("%0d results never arrived", byte_results.size()));
    $display("checked %0d bytes across %0d chunks under varied registers and stalls",
             bytes_checked, chunks_seen);
    $display("cuts by content %0d, by max size %0d, by end of input %0d",
             cut_count[REASON_CONTENT], cut_count[REASON_MAX], cut_count[REASON_LAST]);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
